>>> hdl/multilevel_feedback_queue_scheduler_assert.svh
// Assertion macros for the multilevel feedback queue scheduler.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFQS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MFQS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/mfqs_pkg.sv
// Package with shared types and constants of the multilevel feedback queue scheduler.
package mfqs_pkg;

	localparam int MAX_TASKS  = 64;
	localparam int TIME_BITS  = 23;
	localparam int LEVELS     = 4;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int LVL_W      = 2;
	localparam int SLICE_W    = 9;
	localparam int FIFO_DEPTH = 256;
	localparam int FIFO_AW    = 8;

	// Configuration register indexes.
	localparam logic [1:0] CFG_QUANTUM0 = 2'd0;
	localparam logic [1:0] CFG_QUANTUM1 = 2'd1;
	localparam logic [1:0] CFG_QUANTUM2 = 2'd2;

	// Level codes.
	localparam logic [LVL_W-1:0] LVL_TOP    = 2'd0;
	localparam logic [LVL_W-1:0] LVL_SECOND = 2'd1;
	localparam logic [LVL_W-1:0] LVL_THIRD  = 2'd2;
	localparam logic [LVL_W-1:0] LVL_LAST   = 2'd3;

	typedef struct packed {
		logic [15:0] arrival_time;
		logic [15:0] burst_time;
		logic        last_task;
	} task_word_t;

	typedef struct packed {
		logic [6:0]           task_number;
		logic [TIME_BITS-1:0] completion_time;
		logic [TIME_BITS-1:0] turnaround_time;
		logic [TIME_BITS-1:0] waiting_time;
		logic [TIME_BITS-1:0] response_time;
		logic [SLICE_W-1:0]   slice_count;
		logic                 last_result;
	} result_word_t;

	typedef struct packed {
		logic [7:0] level0;
		logic [7:0] level1;
		logic [7:0] level2;
	} quanta_t;

	// One entry of the task memory.
	typedef struct packed {
		logic [15:0]          arrival;
		logic [15:0]          burst;
		logic [15:0]          remaining;
		logic [TIME_BITS-1:0] response;
		logic [TIME_BITS-1:0] completion;
	} task_entry_t;

	localparam int ENTRY_W = $bits(task_entry_t);

	typedef enum logic [2:0] {
		S_LOAD,
		S_CHECK,
		S_SCAN,
		S_POP,
		S_FETCH,
		S_EXEC,
		S_ORD,
		S_OHOLD
	} sched_state_t;

endpackage

>>> hdl/mfqs_ram.sv
// Generic single-port-write, single-port-read synchronous memory with registered read data.
module mfqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data register holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/mfqs_sched.sv
// Scheduling sequencer: task loading, admission sweeps, dispatch and result readout.
module mfqs_sched (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  task_valid,
	output logic                  task_stall,
	input  mfqs_pkg::task_word_t  task_word,
	output logic                  result_valid,
	input  logic                  result_stall,
	output mfqs_pkg::result_word_t result_word,
	input  mfqs_pkg::quanta_t     quanta
);
	import mfqs_pkg::*;

	sched_state_t state_q, state_d;

	logic [CNT_W-1:0]     task_cnt_q;
	logic [CNT_W-1:0]     done_cnt_q;
	logic [TIME_BITS-1:0] time_q;
	logic [SLICE_W-1:0]   disp_q;
	logic [IDX_W-1:0]     head_q [LEVELS];
	logic [CNT_W-1:0]     cnt_q [LEVELS];
	logic [MAX_TASKS-1:0] started_q;
	logic [MAX_TASKS-1:0] admitted_q;
	logic                 pend_q;
	logic [15:0]          min_q;
	logic                 new_pend_q;
	logic [15:0]          new_min_q;
	logic [CNT_W-1:0]     scan_idx_q;
	logic                 scan_vld_s1;
	logic [IDX_W-1:0]     scan_id_s1;
	logic [LVL_W-1:0]     lvl_q;
	logic [IDX_W-1:0]     id_q;
	logic [IDX_W-1:0]     out_idx_q;

	// Memory ports.
	logic                 tm_we, tm_re;
	logic [IDX_W-1:0]     tm_waddr, tm_raddr;
	task_entry_t          tm_wdata, tm_rdata;
	logic                 fm_we, fm_re;
	logic [FIFO_AW-1:0]   fm_waddr, fm_raddr;
	logic [IDX_W-1:0]     fm_wdata, fm_rdata;

	mfqs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TASKS)) u_task_ram (
		.clk   (clk),
		.we    (tm_we),
		.waddr (tm_waddr),
		.wdata (tm_wdata),
		.re    (tm_re),
		.raddr (tm_raddr),
		.rdata (tm_rdata)
	);

	mfqs_ram #(.WIDTH(IDX_W), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
		.clk   (clk),
		.we    (fm_we),
		.waddr (fm_waddr),
		.wdata (fm_wdata),
		.re    (fm_re),
		.raddr (fm_raddr),
		.rdata (fm_rdata)
	);

	// Decode of common conditions.
	logic                 task_acc, load_ok, all_done, scan_due, any_queued;
	logic                 scan_issue, scan_admit, scan_later, out_acc, out_last;
	logic [LVL_W-1:0]     lvl_pick;
	logic [15:0]          quantum, used, rem_new;
	logic [TIME_BITS-1:0] time_new;
	logic [LVL_W-1:0]     lvl_next;

	always_comb begin
		task_acc   = task_valid && !task_stall;
		load_ok    = task_cnt_q < CNT_W'(MAX_TASKS);
		all_done   = done_cnt_q == task_cnt_q;
		scan_due   = pend_q && (time_q >= {{(TIME_BITS-16){1'b0}}, min_q});
		any_queued = (cnt_q[0] != '0) || (cnt_q[1] != '0) || (cnt_q[2] != '0)
			|| (cnt_q[3] != '0);
		scan_issue = (state_q == S_SCAN) && (scan_idx_q != task_cnt_q);
		scan_admit = (state_q == S_SCAN) && scan_vld_s1 && !admitted_q[scan_id_s1]
			&& ({{(TIME_BITS-16){1'b0}}, tm_rdata.arrival} <= time_q);
		scan_later = (state_q == S_SCAN) && scan_vld_s1 && !admitted_q[scan_id_s1]
			&& !scan_admit;
		out_acc    = result_valid && !result_stall;
		out_last   = (CNT_W'(out_idx_q) + CNT_W'(1)) == task_cnt_q;
	end

	// First non-empty level, top priority first.
	always_comb begin
		if (cnt_q[0] != '0) begin
			lvl_pick = LVL_TOP;
		end else if (cnt_q[1] != '0) begin
			lvl_pick = LVL_SECOND;
		end else if (cnt_q[2] != '0) begin
			lvl_pick = LVL_THIRD;
		end else begin
			lvl_pick = LVL_LAST;
		end
	end

	// Slice length of the dispatched task.
	always_comb begin
		case (lvl_q)
			LVL_TOP:    quantum = {8'd0, quanta.level0};
			LVL_SECOND: quantum = {8'd0, quanta.level1};
			LVL_THIRD:  quantum = {8'd0, quanta.level2};
			default:    quantum = tm_rdata.remaining;
		endcase
		used     = (quantum < tm_rdata.remaining) ? quantum : tm_rdata.remaining;
		rem_new  = tm_rdata.remaining - used;
		time_new = time_q + {{(TIME_BITS-16){1'b0}}, used};
		lvl_next = lvl_q + LVL_W'(1);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				if (task_acc && task_word.last_task) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (all_done) begin
					state_d = S_ORD;
				end else if (scan_due) begin
					state_d = S_SCAN;
				end else if (any_queued) begin
					state_d = S_POP;
				end
			end
			S_SCAN: begin
				if (!scan_issue && !scan_vld_s1) begin
					state_d = S_CHECK;
				end
			end
			S_POP:   state_d = S_FETCH;
			S_FETCH: state_d = S_EXEC;
			S_EXEC:  state_d = S_CHECK;
			S_ORD:   state_d = S_OHOLD;
			S_OHOLD: begin
				if (!result_stall) begin
					state_d = out_last ? S_LOAD : S_ORD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	// Outputs and memory controls.
	always_comb begin
		task_stall   = state_q != S_LOAD;
		result_valid = state_q == S_OHOLD;

		tm_we    = 1'b0;
		tm_waddr = task_cnt_q[IDX_W-1:0];
		tm_wdata = tm_rdata;
		tm_re    = 1'b0;
		tm_raddr = scan_idx_q[IDX_W-1:0];
		fm_we    = 1'b0;
		fm_waddr = {LVL_TOP, head_q[0] + cnt_q[0][IDX_W-1:0]};
		fm_wdata = scan_id_s1;
		fm_re    = 1'b0;
		fm_raddr = {lvl_pick, head_q[lvl_pick]};

		case (state_q)
			S_LOAD: begin
				tm_we            = task_acc && load_ok;
				tm_wdata.arrival   = task_word.arrival_time;
				tm_wdata.burst     = task_word.burst_time;
				tm_wdata.remaining = task_word.burst_time;
			end
			S_SCAN: begin
				tm_re = scan_issue;
				fm_we = scan_admit;
			end
			S_POP: begin
				fm_re = 1'b1;
			end
			S_FETCH: begin
				tm_re    = 1'b1;
				tm_raddr = fm_rdata;
			end
			S_EXEC: begin
				tm_we              = 1'b1;
				tm_waddr           = id_q;
				tm_wdata.remaining = rem_new;
				if (!started_q[id_q]) begin
					tm_wdata.response = time_q - {{(TIME_BITS-16){1'b0}}, tm_rdata.arrival};
				end
				if (rem_new == '0) begin
					tm_wdata.completion = time_new;
				end
				fm_we    = rem_new != '0;
				fm_waddr = {lvl_next, head_q[lvl_next] + cnt_q[lvl_next][IDX_W-1:0]};
				fm_wdata = id_q;
			end
			S_ORD: begin
				tm_re    = 1'b1;
				tm_raddr = out_idx_q;
			end
			default: begin
			end
		endcase
	end

	// Result fields from the registered memory word.
	logic [TIME_BITS-1:0] tat;
	always_comb begin
		tat = tm_rdata.completion - {{(TIME_BITS-16){1'b0}}, tm_rdata.arrival};
		result_word.task_number     = 7'(out_idx_q) + 7'd1;
		result_word.completion_time = tm_rdata.completion;
		result_word.turnaround_time = tat;
		result_word.waiting_time    = tat - {{(TIME_BITS-16){1'b0}}, tm_rdata.burst};
		result_word.response_time   = tm_rdata.response;
		result_word.slice_count     = disp_q;
		result_word.last_result     = out_last;
	end

	// State and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			task_cnt_q  <= '0;
			done_cnt_q  <= '0;
			time_q      <= '0;
			disp_q      <= '0;
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
			started_q   <= '0;
			admitted_q  <= '0;
			pend_q      <= 1'b1;
			min_q       <= '0;
			new_pend_q  <= 1'b0;
			new_min_q   <= '0;
			scan_idx_q  <= '0;
			scan_vld_s1 <= 1'b0;
			scan_id_s1  <= '0;
			lvl_q       <= LVL_TOP;
			id_q        <= '0;
			out_idx_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_LOAD: begin
					if (task_acc && load_ok) begin
						task_cnt_q <= task_cnt_q + CNT_W'(1);
					end
				end
				S_CHECK: begin
					if (!all_done && scan_due) begin
						scan_idx_q <= '0;
						new_pend_q <= 1'b0;
					end else if (!all_done && !any_queued) begin
						// Nothing queued: jump straight to the next arrival.
						time_q <= {{(TIME_BITS-16){1'b0}}, min_q};
					end
					out_idx_q <= '0;
				end
				S_SCAN: begin
					scan_vld_s1 <= scan_issue;
					scan_id_s1  <= scan_idx_q[IDX_W-1:0];
					if (scan_issue) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end
					if (scan_admit) begin
						admitted_q[scan_id_s1] <= 1'b1;
						cnt_q[0]               <= cnt_q[0] + CNT_W'(1);
					end
					if (scan_later && (!new_pend_q || tm_rdata.arrival < new_min_q)) begin
						new_pend_q <= 1'b1;
						new_min_q  <= tm_rdata.arrival;
					end
					if (!scan_issue && !scan_vld_s1) begin
						pend_q <= new_pend_q;
						min_q  <= new_min_q;
					end
				end
				S_POP: begin
					lvl_q            <= lvl_pick;
					head_q[lvl_pick] <= head_q[lvl_pick] + IDX_W'(1);
					cnt_q[lvl_pick]  <= cnt_q[lvl_pick] - CNT_W'(1);
				end
				S_FETCH: begin
					id_q <= fm_rdata;
				end
				S_EXEC: begin
					time_q          <= time_new;
					disp_q          <= disp_q + SLICE_W'(1);
					started_q[id_q] <= 1'b1;
					if (rem_new == '0) begin
						done_cnt_q <= done_cnt_q + CNT_W'(1);
					end else begin
						cnt_q[lvl_next] <= cnt_q[lvl_next] + CNT_W'(1);
					end
				end
				S_OHOLD: begin
					if (out_acc) begin
						out_idx_q <= out_idx_q + IDX_W'(1);
						if (out_last) begin
							// Set finished: back to an empty schedule.
							task_cnt_q <= '0;
							done_cnt_q <= '0;
							time_q     <= '0;
							disp_q     <= '0;
							for (int l = 0; l < LEVELS; l++) begin
								head_q[l] <= '0;
								cnt_q[l]  <= '0;
							end
							started_q  <= '0;
							admitted_q <= '0;
							pend_q     <= 1'b1;
							min_q      <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> hdl/multilevel_feedback_queue_scheduler.sv
// Top level of the four-level feedback queue scheduler with its quantum registers.
//
//  Channel  Handshake             Word
//  task     task_valid/stall      arrival_time, burst_time, last_task
//  result   result_valid/stall    task number, times, slice count, last mark
//  cfg      cfg_valid/ready       cfg_index, cfg_data (level quanta)
//
// Task words load at one per cycle until the word with last_task closes the input and runs
// the schedule: each dispatch steps through check, queue pop, task fetch and write back, and
// an admission sweep over the task memory runs whenever the time reaches a pending arrival.
// Results then leave one at a time, each read from the task memory before it is offered.
// Reset leaves an empty schedule with no clearing pass; a stalled result holds its word
// and the scheduler waits.
module multilevel_feedback_queue_scheduler (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   task_valid,
	output logic                   task_stall,
	input  mfqs_pkg::task_word_t   task_word,
	output logic                   result_valid,
	input  logic                   result_stall,
	output mfqs_pkg::result_word_t result_word,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [7:0]             cfg_data
);
	import mfqs_pkg::*;

	`include "multilevel_feedback_queue_scheduler_assert.svh"

	quanta_t quanta_q;

	assign cfg_ready = 1'b1;

	// Quantum registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quanta_q.level0 <= 8'd2;
			quanta_q.level1 <= 8'd4;
			quanta_q.level2 <= 8'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_QUANTUM0: quanta_q.level0 <= cfg_data;
				CFG_QUANTUM1: quanta_q.level1 <= cfg_data;
				CFG_QUANTUM2: quanta_q.level2 <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mfqs_sched u_sched (
		.clk          (clk),
		.arst_n       (arst_n),
		.task_valid   (task_valid),
		.task_stall   (task_stall),
		.task_word    (task_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word),
		.quanta       (quanta_q)
	);

	// No task word is taken while results are being delivered.
	`MFQS_ASSERT_SAME(a_no_load_during_results, result_valid, task_stall, "task taken during results")
	// The last task word starts the schedule and closes the input.
	`MFQS_ASSERT_NEXT(a_last_closes_input, task_valid && !task_stall && task_word.last_task, task_stall, "input open after last task")
	// After the final result the block is ready for a new set.
	`MFQS_ASSERT_NEXT(a_reopen_after_set, result_valid && !result_stall && result_word.last_result, !task_stall && !result_valid, "not ready after final result")

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the four-level feedback queue scheduler.
module tb_top;
	import mfqs_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         task_valid;
	logic         task_stall;
	task_word_t   task_word;
	logic         result_valid;
	logic         result_stall;
	result_word_t result_word;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [7:0]   cfg_data;

	multilevel_feedback_queue_scheduler DUT (
		.clk(clk), .arst_n(arst_n),
		.task_valid(task_valid), .task_stall(task_stall), .task_word(task_word),
		.result_valid(result_valid), .result_stall(result_stall),
		.result_word(result_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	typedef struct {
		task_word_t   w;
		bit           typed;
		result_word_t r;
	} stim_row_t;

	// Shadow copies of the quanta and of the task set being loaded.
	quanta_t        quanta;
	logic [15:0]    set_arrival [MAX_TASKS];
	logic [15:0]    set_burst [MAX_TASKS];
	int             set_size;
	result_word_t   schedule_results[$];
	int             fail_count;
	int             hold_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Runs the whole feedback schedule of the loaded set and queues one word per task.
	function automatic void schedule_set();
		int                   remaining [MAX_TASKS];
		logic [TIME_BITS-1:0] first_run [MAX_TASKS];
		logic [TIME_BITS-1:0] finish [MAX_TASKS];
		bit                   started [MAX_TASKS];
		bit                   admitted [MAX_TASKS];
		int                   level_q [LEVELS][$];
		logic [TIME_BITS-1:0] now;
		logic [TIME_BITS-1:0] tat;
		logic [SLICE_W-1:0]   slices;
		int                   done;
		int                   lvl;
		int                   id;
		int                   used;
		int                   q;
		result_word_t         r;
		for (int i = 0; i < set_size; i++) begin
			remaining[i] = int'(set_burst[i]);
			started[i] = 0;
			admitted[i] = 0;
		end
		now = '0;
		slices = '0;
		done = 0;
		while (done < set_size) begin
			for (int i = 0; i < set_size; i++) begin
				if (!admitted[i] && set_arrival[i] <= now) begin
					level_q[0].push_back(i);
					admitted[i] = 1;
				end
			end
			lvl = 0;
			while (lvl < LEVELS && level_q[lvl].size() == 0)
				lvl++;
			if (lvl == LEVELS) begin
				now = now + 1'b1;
				continue;
			end
			id = level_q[lvl].pop_front();
			used = remaining[id];
			if (!started[id]) begin
				first_run[id] = now - set_arrival[id];
				started[id] = 1;
			end
			// The bottom level runs a task to completion.
			if (lvl < 3) begin
				q = (lvl == LVL_TOP) ? int'(quanta.level0) :
					(lvl == LVL_SECOND) ? int'(quanta.level1) : int'(quanta.level2);
				if (q < used)
					used = q;
			end
			remaining[id] -= used;
			now = now + TIME_BITS'(used);
			if (remaining[id] == 0) begin
				finish[id] = now;
				done++;
			end else begin
				level_q[lvl + 1].push_back(id);
			end
			slices = slices + 1'b1;
		end
		for (int i = 0; i < set_size; i++) begin
			tat = finish[i] - set_arrival[i];
			r.task_number = 7'(i + 1);
			r.completion_time = finish[i];
			r.turnaround_time = tat;
			r.waiting_time = tat - set_burst[i];
			r.response_time = first_run[i];
			r.slice_count = slices;
			r.last_result = (i + 1 == set_size);
			schedule_results.push_back(r);
		end
		set_size = 0;
	endfunction

	// Records one accepted task word; tasks beyond the table size are dropped.
	function automatic void load_task(task_word_t w);
		if (set_size < MAX_TASKS) begin
			set_arrival[set_size] = w.arrival_time;
			set_burst[set_size] = w.burst_time;
			set_size++;
		end
		if (w.last_task)
			schedule_set();
	endfunction

	function automatic void check_field(string name, longint unsigned exp_v,
			longint unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	function automatic void compare_result(result_word_t e, result_word_t a);
		check_field("task_number", e.task_number, a.task_number);
		check_field("completion_time", e.completion_time, a.completion_time);
		check_field("turnaround_time", e.turnaround_time, a.turnaround_time);
		check_field("waiting_time", e.waiting_time, a.waiting_time);
		check_field("response_time", e.response_time, a.response_time);
		check_field("slice_count", e.slice_count, a.slice_count);
		check_field("last_result", e.last_result, a.last_result);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic task_word_t random_word(bit last);
		task_word_t w;
		int r;
		r = $urandom_range(0, 99);
		w.arrival_time = (r < 85) ? 16'($urandom_range(0, 300)) : 16'($urandom);
		r = $urandom_range(0, 99);
		w.burst_time = (r < 70) ? 16'($urandom_range(0, 40)) :
			(r < 92) ? 16'($urandom_range(0, 1000)) : 16'($urandom);
		w.last_task = last;
		return w;
	endfunction

	// Offers one task word after a random gap and waits for it to be taken.
	task automatic send_task(task_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			task_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		task_valid <= 1'b1;
		task_word <= w;
		do @(posedge clk); while (task_stall);
		load_task(w);
		@(negedge clk);
	endtask

	task automatic send_random_set(int n);
		for (int i = 0; i < n; i++)
			send_task(random_word(i == n - 1));
		task_valid <= 1'b0;
	endtask

	task automatic write_quantum(logic [1:0] idx, logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_QUANTUM0: quanta.level0 = value;
			CFG_QUANTUM1: quanta.level1 = value;
			default: quanta.level2 = value;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every queued result word has been seen, then lets the block settle.
	task automatic wait_drained();
		wait (schedule_results.size() == 0);
		repeat (50) @(posedge clk);
		@(negedge clk);
	endtask

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (schedule_results.size() == 0) begin
				$error("result word with nothing expected, task_number %0d",
					result_word.task_number);
				fail_count++;
			end else begin
				compare_result(schedule_results.pop_front(), result_word);
			end
		end
	end

	// Result-side stalls, with one long hold-off on request.
	initial begin
		int n;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				result_stall <= 1'b1;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
				result_stall <= 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					result_stall <= 1'b1;
					repeat (n) @(negedge clk);
				end
				result_stall <= 1'b0;
			end
		end
	end

	// Main stimulus.
	initial begin
		stim_row_t   rows[$];
		stim_row_t   row;
		logic [7:0]  q_set [3];
		task_valid = 1'b0;
		task_word = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_QUANTUM0;
		cfg_data = '0;
		fail_count = 0;
		hold_cycles = 0;
		set_size = 0;
		quanta.level0 = 8'd2;
		quanta.level1 = 8'd4;
		quanta.level2 = 8'd8;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed sets at the reset quanta: single tasks have known results.
		rows.push_back('{'{16'd0, 16'd0, 1'b1}, 1,
			'{7'd1, 23'd0, 23'd0, 23'd0, 23'd0, 9'd1, 1'b1}});
		rows.push_back('{'{16'hFFFF, 16'd0, 1'b1}, 1,
			'{7'd1, 23'd65535, 23'd0, 23'd0, 23'd0, 9'd1, 1'b1}});
		rows.push_back('{'{16'd0, 16'hFFFF, 1'b1}, 1,
			'{7'd1, 23'd65535, 23'd65535, 23'd0, 23'd0, 9'd4, 1'b1}});
		rows.push_back('{'{16'd100, 16'd3, 1'b1}, 1,
			'{7'd1, 23'd103, 23'd3, 23'd0, 23'd0, 9'd2, 1'b1}});
		rows.push_back('{'{16'd0, 16'd5, 1'b0}, 0, '0});
		rows.push_back('{'{16'd0, 16'd5, 1'b0}, 0, '0});
		rows.push_back('{'{16'd1, 16'd1, 1'b0}, 0, '0});
		rows.push_back('{'{16'd3, 16'd0, 1'b0}, 0, '0});
		rows.push_back('{'{16'd50, 16'd20, 1'b1}, 0, '0});
		rows.push_back('{'{16'hFFFF, 16'hFFFF, 1'b0}, 0, '0});
		rows.push_back('{'{16'd0, 16'd1, 1'b0}, 0, '0});
		rows.push_back('{'{16'hFFFF, 16'd1, 1'b1}, 0, '0});
		rows.push_back('{'{16'd7, 16'd10, 1'b0}, 0, '0});
		rows.push_back('{'{16'd7, 16'd10, 1'b1}, 0, '0});
		rows.push_back('{'{16'hAAAA, 16'h5555, 1'b0}, 0, '0});
		rows.push_back('{'{16'h5555, 16'hAAAA, 1'b1}, 0, '0});
		foreach (rows[k]) begin
			row = rows[k];
			send_task(row.w);
			if (row.typed) begin
				if (schedule_results.size() == 0) begin
					$error("no result predicted for a single-task set");
					fail_count++;
				end else begin
					compare_result(row.r, schedule_results[$]);
				end
			end
		end
		task_valid <= 1'b0;

		// Random phases, each at its own quanta, with the extremes first.
		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			case (ph)
				0: q_set = '{8'd1, 8'd1, 8'd1};
				1: q_set = '{8'd255, 8'd255, 8'd255};
				2: q_set = '{8'd0, 8'd0, 8'd0};
				default: q_set = '{8'($urandom_range(0, 255)),
					8'($urandom_range(1, 20)), 8'($urandom_range(0, 255))};
			endcase
			write_quantum(CFG_QUANTUM0, q_set[0]);
			write_quantum(CFG_QUANTUM1, q_set[1]);
			write_quantum(CFG_QUANTUM2, q_set[2]);
			// The receiver holds off long while new sets keep coming.
			if (ph == 1)
				hold_cycles = 400;
			send_random_set($urandom_range(1, 4));
			send_random_set($urandom_range(3, 8));
			// More tasks than the table holds: the extras are dropped.
			if (ph == 3)
				send_random_set(MAX_TASKS + 2);
		end

		wait_drained();
		if (fail_count == 0)
			$display("PASS multilevel_feedback_queue_scheduler");
		else
			$display("FAIL multilevel_feedback_queue_scheduler");
		$finish;
	end

	// Watchdog.
	initial begin
		#(20 * 4000000);
		$display("FAIL multilevel_feedback_queue_scheduler");
		$finish;
	end

endmodule
